### rtl/core/pwbs_pkg.sv
// Types, constants and helpers shared by the pulse-width bit sender.
`default_nettype none

package pwbs_pkg;

  localparam int WORD_BITS = 16;
  localparam int CountW    = 5;
  localparam int UnitW     = 8;
  localparam int RegIdxW   = 3;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SEND = 1'b1;

  localparam logic [RegIdxW-1:0] REG_START = 3'd0;
  localparam logic [RegIdxW-1:0] REG_GAP   = 3'd1;
  localparam logic [RegIdxW-1:0] REG_ONE   = 3'd2;
  localparam logic [RegIdxW-1:0] REG_ZERO  = 3'd3;
  localparam logic [RegIdxW-1:0] REG_STOP  = 3'd4;

  localparam logic [UnitW-1:0] START_RST = 8'd30;
  localparam logic [UnitW-1:0] GAP_RST   = 8'd2;
  localparam logic [UnitW-1:0] ONE_RST   = 8'd10;
  localparam logic [UnitW-1:0] ZERO_RST  = 8'd5;
  localparam logic [UnitW-1:0] STOP_RST  = 8'd20;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_START = 6'b000010,
    PH_GAP   = 6'b000100,
    PH_BIT   = 6'b001000,
    PH_STOP  = 6'b010000,
    PH_FINAL = 6'b100000
  } phase_e;

  typedef struct packed {
    logic                 opcode;
    logic [WORD_BITS-1:0] word_in;
    logic [CountW-1:0]    bit_count;
  } in_item_t;

  typedef struct packed {
    logic pin_level;
    logic busy_res;
    logic frame_done;
    logic rejected;
  } out_item_t;

  typedef struct packed {
    logic [UnitW-1:0] start_units;
    logic [UnitW-1:0] gap_units;
    logic [UnitW-1:0] one_units;
    logic [UnitW-1:0] zero_units;
    logic [UnitW-1:0] stop_units;
  } cfg_t;

  // a zero length counts as one tick
  function automatic logic [UnitW-1:0] len_of(input logic [UnitW-1:0] units);
    len_of = (units == '0) ? UnitW'(1) : units;
  endfunction

endpackage

`default_nettype wire

### rtl/core/pwbs_regs.sv
// Timing register file of the pulse-width bit sender.
`default_nettype none

module pwbs_regs import pwbs_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [RegIdxW-1:0] cfg_idx_i,
  input  wire logic [UnitW-1:0]   cfg_wdata_i,
  output cfg_t                    cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_START: cfg_d.start_units = cfg_wdata_i;
        REG_GAP:   cfg_d.gap_units   = cfg_wdata_i;
        REG_ONE:   cfg_d.one_units   = cfg_wdata_i;
        REG_ZERO:  cfg_d.zero_units  = cfg_wdata_i;
        REG_STOP:  cfg_d.stop_units  = cfg_wdata_i;
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_units <= START_RST;
      cfg_q.gap_units   <= GAP_RST;
      cfg_q.one_units   <= ONE_RST;
      cfg_q.zero_units  <= ZERO_RST;
      cfg_q.stop_units  <= STOP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### rtl/core/pwbs_frame.sv
// Frame sequencer: phase, tick counter, shift word and pin level.
`default_nettype none

module pwbs_frame import pwbs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic step_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t res_o
);

  phase_e               phase_q, phase_d;
  logic [UnitW-1:0]     unit_q, unit_d;
  logic [WORD_BITS-1:0] shift_q, shift_d;
  logic [CountW-1:0]    bits_q, bits_d;
  logic                 pin_q, pin_d;
  logic [UnitW-1:0]     unit_dec;
  logic                 done;
  logic                 rej;

  assign unit_dec = (unit_q != '0) ? unit_q - UnitW'(1) : unit_q;

  always_comb begin
    phase_d = phase_q;
    unit_d  = unit_q;
    shift_d = shift_q;
    bits_d  = bits_q;
    pin_d   = pin_q;
    done    = 1'b0;
    rej     = 1'b0;
    if (step_i) begin
      if (item_i.opcode == OP_SEND) begin
        if (phase_q != PH_IDLE) begin
          rej = 1'b1;
        end else begin
          shift_d = item_i.word_in;
          bits_d  = (item_i.bit_count > CountW'(WORD_BITS)) ? CountW'(WORD_BITS)
                                                            : item_i.bit_count;
          phase_d = PH_START;
          pin_d   = 1'b1;
          unit_d  = len_of(cfg_i.start_units);
        end
      end else if (phase_q != PH_IDLE) begin
        unit_d = unit_dec;
        if (unit_dec == '0) begin
          unique case (phase_q)
            PH_START: begin
              phase_d = PH_GAP;
              pin_d   = 1'b0;
              unit_d  = len_of(cfg_i.gap_units);
            end
            PH_GAP: begin
              pin_d = 1'b1;
              if (bits_q != '0) begin
                phase_d = PH_BIT;
                unit_d  = shift_q[0] ? len_of(cfg_i.one_units)
                                     : len_of(cfg_i.zero_units);
              end else begin
                phase_d = PH_STOP;
                unit_d  = len_of(cfg_i.stop_units);
              end
            end
            PH_BIT: begin
              shift_d = shift_q >> 1;
              bits_d  = bits_q - CountW'(1);
              phase_d = PH_GAP;
              pin_d   = 1'b0;
              unit_d  = len_of(cfg_i.gap_units);
            end
            PH_STOP: begin
              phase_d = PH_FINAL;
              pin_d   = 1'b0;
              unit_d  = len_of(cfg_i.gap_units);
            end
            default: begin
              phase_d = PH_IDLE;
              pin_d   = 1'b0;
              unit_d  = '0;
              done    = 1'b1;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      unit_q  <= '0;
      shift_q <= '0;
      bits_q  <= '0;
      pin_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      unit_q  <= unit_d;
      shift_q <= shift_d;
      bits_q  <= bits_d;
      pin_q   <= pin_d;
    end
  end

  assign res_o.pin_level  = pin_d;
  assign res_o.busy_res   = (phase_d != PH_IDLE);
  assign res_o.frame_done = done;
  assign res_o.rejected   = rej;

  a_pin_in_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pin_q |-> (phase_q == PH_START || phase_q == PH_BIT || phase_q == PH_STOP))
    else $error("pin high outside a pulse phase");

  a_busy_has_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_IDLE) |-> (unit_q != '0))
    else $error("active phase with no ticks left");

  a_bits_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_q <= CountW'(WORD_BITS))
    else $error("bit count above word width");

  a_send_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && item_i.opcode == OP_SEND && phase_q == PH_IDLE)
      |=> (phase_q == PH_START && pin_q))
    else $error("send while idle did not open a start pulse");

  a_busy_send_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && item_i.opcode == OP_SEND && phase_q != PH_IDLE)
      |=> ($stable(phase_q) && $stable(unit_q) && $stable(shift_q)))
    else $error("rejected send disturbed the frame");

endmodule

`default_nettype wire

### rtl/core/pulse_width_bit_sender_top.sv
// Top level of the pulse-width bit sender: registers, sequencer, result register.
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  input   | in_valid_i, in_stall_o, in_data_i    | in
//  output  | out_valid_o, out_stall_i, out_data_o | out
//  config  | cfg_we_i, cfg_idx_i, cfg_wdata_i     | in
//
// One item per cycle while in_stall_o is low: each transfer passes the sequencer
// combinationally and lands in the result register the edge it is taken.
// Results show the cycle after intake; the register frees in the cycle it is taken.
// Reset is asynchronous; no clearing pass, the block takes items right after it.
// in_stall_o rises only while a held result is stalled at the output.
`default_nettype none

module pulse_width_bit_sender_top import pwbs_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  in_item_t                in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output out_item_t               out_data_o,
  input  wire logic               cfg_we_i,
  input  wire logic [RegIdxW-1:0] cfg_idx_i,
  input  wire logic [UnitW-1:0]   cfg_wdata_i
);

  cfg_t      cfg;
  out_item_t res;
  logic      step;
  logic      out_valid_q, out_valid_d;
  out_item_t out_data_q;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign step       = in_valid_i & ~in_stall_o;

  pwbs_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  pwbs_frame u_frame (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(step),
    .item_i(in_data_i),
    .cfg_i (cfg),
    .res_o (res)
  );

  assign out_valid_d = step | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the pulse-width bit sender: directed table, then random frames.
`timescale 1ns / 100ps

module tb_top import pwbs_pkg::*; ();

  localparam int RAND_ITEMS = 180;
  localparam int CALM_ITEMS = 60;

  typedef enum logic [1:0] {ROW_ITEM, ROW_CFG, ROW_FLUSH} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    in_item_t             item;
    logic                 typed;
    out_item_t            exp;
    logic [RegIdxW-1:0]   idx;
    logic [UnitW-1:0]     val;
  } dir_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_data;
  logic               cfg_we = 1'b0;
  logic [RegIdxW-1:0] cfg_idx = '0;
  logic [UnitW-1:0]   cfg_wdata = '0;

  logic      typed_valid = 1'b0;
  out_item_t typed_exp = '0;
  logic      calm = 1'b0;
  int        stall_left = 0;
  int        rand_items = 0;
  int        mismatches = 0;
  out_item_t got_exp;
  out_item_t pred_res;

  out_item_t pending_results [$];

  phase_e               sim_phase = PH_IDLE;
  logic [UnitW-1:0]     sim_units = '0;
  logic [WORD_BITS-1:0] sim_word = '0;
  logic [CountW-1:0]    sim_bits = '0;
  logic                 sim_pin = 1'b0;
  cfg_t                 sim_cfg = '{START_RST, GAP_RST, ONE_RST, ZERO_RST, STOP_RST};

  pulse_width_bit_sender_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  function automatic dir_row_t row_item(logic op, logic [WORD_BITS-1:0] w,
                                        logic [CountW-1:0] c, logic typed, logic [3:0] e);
    dir_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.item = '{op, w, c};
    r.typed = typed;
    r.exp = out_item_t'(e);
    return r;
  endfunction

  function automatic dir_row_t row_cfg(logic [RegIdxW-1:0] idx, logic [UnitW-1:0] val);
    dir_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  function automatic dir_row_t row_flush();
    dir_row_t r;
    r = '0;
    r.kind = ROW_FLUSH;
    return r;
  endfunction

  localparam dir_row_t DIR_ROWS [23] = '{
    row_item(OP_TICK, 16'hFFFF, 5'd31, 1'b1, 4'b0000),
    row_item(OP_SEND, 16'hFFFF, 5'd4,  1'b1, 4'b1100),
    row_item(OP_SEND, 16'h1234, 5'd3,  1'b1, 4'b1101),
    row_item(OP_TICK, 16'h0000, 5'd0,  1'b0, 4'b0000),
    row_flush(),
    row_item(OP_TICK, 16'h0000, 5'd0,  1'b1, 4'b0000),
    row_cfg(REG_START, 8'd0),
    row_cfg(REG_GAP,   8'd0),
    row_cfg(REG_ONE,   8'd2),
    row_cfg(REG_ZERO,  8'd1),
    row_cfg(REG_STOP,  8'd0),
    row_item(OP_SEND, 16'h0000, 5'd16, 1'b1, 4'b1100),
    row_flush(),
    row_item(OP_SEND, 16'hA5A5, 5'd31, 1'b1, 4'b1100),
    row_item(OP_SEND, 16'hFFFF, 5'd0,  1'b1, 4'b1101),
    row_flush(),
    row_item(OP_SEND, 16'hFFFF, 5'd0,  1'b1, 4'b1100),
    row_flush(),
    row_cfg(REG_STOP + 1'b1,    8'hFF),
    row_cfg({RegIdxW{1'b1}},    8'hAA),
    row_item(OP_SEND, 16'h5A5A, 5'd17, 1'b1, 4'b1100),
    row_flush(),
    row_item(OP_TICK, 16'hFFFF, 5'd31, 1'b1, 4'b0000)
  };

  function automatic void load_phase(phase_e p, logic lvl, logic [UnitW-1:0] units);
    sim_phase = p;
    sim_pin   = lvl;
    sim_units = (units == '0) ? UnitW'(1) : units;
  endfunction

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t res;
    res = '0;
    if (it.opcode == OP_SEND) begin
      if (sim_phase != PH_IDLE) begin
        res.rejected = 1'b1;
      end else begin
        sim_word = it.word_in;
        sim_bits = (it.bit_count > WORD_BITS) ? CountW'(WORD_BITS) : it.bit_count;
        load_phase(PH_START, 1'b1, sim_cfg.start_units);
      end
    end else if (sim_phase != PH_IDLE) begin
      if (sim_units != '0) sim_units = sim_units - 1'b1;
      if (sim_units == '0) begin
        case (sim_phase)
          PH_START: load_phase(PH_GAP, 1'b0, sim_cfg.gap_units);
          PH_GAP: begin
            if (sim_bits != '0)
              load_phase(PH_BIT, 1'b1, sim_word[0] ? sim_cfg.one_units : sim_cfg.zero_units);
            else
              load_phase(PH_STOP, 1'b1, sim_cfg.stop_units);
          end
          PH_BIT: begin
            sim_word = sim_word >> 1;
            sim_bits = sim_bits - 1'b1;
            load_phase(PH_GAP, 1'b0, sim_cfg.gap_units);
          end
          PH_STOP: load_phase(PH_FINAL, 1'b0, sim_cfg.gap_units);
          default: begin
            sim_phase = PH_IDLE;
            sim_pin = 1'b0;
            sim_units = '0;
            res.frame_done = 1'b1;
          end
        endcase
      end
    end
    res.pin_level = sim_pin;
    res.busy_res = (sim_phase != PH_IDLE);
    return res;
  endfunction

  function automatic void check_field(string name, logic want, logic got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %b, actual %b", $time, name, want, got);
    end
  endfunction

  function automatic in_item_t tick_item();
    in_item_t t;
    t.opcode = OP_TICK;
    t.word_in = WORD_BITS'($urandom_range(0, 65535));
    t.bit_count = CountW'($urandom_range(0, 31));
    return t;
  endfunction

  function automatic in_item_t send_item(logic short_bits);
    in_item_t t;
    t.opcode = OP_SEND;
    t.word_in = WORD_BITS'($urandom_range(0, 65535));
    if (short_bits)
      t.bit_count = CountW'($urandom_range(0, 1));
    else if ($urandom_range(0, 3) == 0)
      t.bit_count = CountW'($urandom_range(17, 31));
    else
      t.bit_count = CountW'($urandom_range(0, 16));
    return t;
  endfunction

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(negedge clk_i) begin
    if (!rst_ni || calm) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected result, expected none, actual %b", $time, out_data);
        end else begin
          got_exp = pending_results.pop_front();
          check_field("pin_level", got_exp.pin_level, out_data.pin_level);
          check_field("busy_res", got_exp.busy_res, out_data.busy_res);
          check_field("frame_done", got_exp.frame_done, out_data.frame_done);
          check_field("rejected", got_exp.rejected, out_data.rejected);
        end
      end
      if (in_valid && !in_stall) begin
        pred_res = predict_result(in_data);
        pending_results.push_back(typed_valid ? typed_exp : pred_res);
      end
    end
  end

  task automatic drive_item(input in_item_t it, input logic typed, input out_item_t exp);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_data = it;
    typed_valid = typed;
    typed_exp = exp;
    in_valid = 1'b1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
    rand_items++;
  endtask

  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [UnitW-1:0] val);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = val;
    @(negedge clk_i);
    cfg_we = 1'b0;
    case (idx)
      REG_START: sim_cfg.start_units = val;
      REG_GAP:   sim_cfg.gap_units = val;
      REG_ONE:   sim_cfg.one_units = val;
      REG_ZERO:  sim_cfg.zero_units = val;
      REG_STOP:  sim_cfg.stop_units = val;
      default: ;
    endcase
  endtask

  task automatic write_all(input int lo, input int hi);
    write_reg(REG_START, UnitW'($urandom_range(lo, hi)));
    write_reg(REG_GAP,   UnitW'($urandom_range(lo, hi)));
    write_reg(REG_ONE,   UnitW'($urandom_range(lo, hi)));
    write_reg(REG_ZERO,  UnitW'($urandom_range(lo, hi)));
    write_reg(REG_STOP,  UnitW'($urandom_range(lo, hi)));
    if ($urandom_range(0, 2) == 0)
      write_reg(RegIdxW'($urandom_range(REG_STOP + 1, {RegIdxW{1'b1}})),
                UnitW'($urandom_range(0, 255)));
  endtask

  task automatic flush_frame();
    while (sim_phase != PH_IDLE) drive_item(tick_item(), 1'b0, '0);
  endtask

  task automatic run_frame(input logic short_bits);
    repeat ($urandom_range(0, 2)) drive_item(tick_item(), 1'b0, '0);
    drive_item(send_item(short_bits), 1'b0, '0);
    while (sim_phase != PH_IDLE) begin
      if ($urandom_range(0, 24) == 0)
        drive_item(send_item(1'b0), 1'b0, '0);
      else
        drive_item(tick_item(), 1'b0, '0);
    end
  endtask

  initial begin
    int frames;
    int wait_cycles;
    frames = 0;
    wait_cycles = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < $size(DIR_ROWS); i++) begin
      case (DIR_ROWS[i].kind)
        ROW_ITEM:  drive_item(DIR_ROWS[i].item, DIR_ROWS[i].typed, DIR_ROWS[i].exp);
        ROW_CFG:   write_reg(DIR_ROWS[i].idx, DIR_ROWS[i].val);
        default:   flush_frame();
      endcase
    end

    write_all(0, 0);
    repeat (3) run_frame(1'b0);
    write_all(1, 1);
    write_reg(REG_START, 8'hFF);
    run_frame(1'b1);

    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      if (frames % 4 == 0) write_all(0, 4);
      calm = (rand_items >= RAND_ITEMS - CALM_ITEMS);
      run_frame(1'b0);
      frames++;
    end

    in_valid = 1'b0;
    while (pending_results.size() != 0 && wait_cycles < 1000) begin
      @(negedge clk_i);
      wait_cycles++;
    end
    repeat (4) @(negedge clk_i);
    if (pending_results.size() != 0) begin
      mismatches++;
      $display("%0t ns: %0d results missing, expected %b first, actual none",
               $time, pending_results.size(), pending_results[0]);
    end
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
